FILE: hdl/tmc_pkg.sv
// Package for the template match counter: payload, job and write-port
// structs, register indexes, reset values and multiplier constants.
// No dependencies.
`timescale 1ns / 1ps

package tmc_pkg;

    // Result counters
    localparam int COUNT_W = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int PIX_W = 8;

    // Job and write-port field widths, sized for the largest supported geometry
    localparam int COL_W   = 12;
    localparam int SLOT_W  = 6;
    localparam int DIM_W   = 7;
    localparam int TADDR_W = 12;

    // Register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_TEMPLATE_W = 3'd1;
    localparam logic [2:0] REG_TEMPLATE_H = 3'd2;
    localparam logic [2:0] REG_IMAGE_W    = 3'd3;
    localparam logic [2:0] REG_MATCH_THR  = 3'd4;
    localparam logic [2:0] REG_ANGLE_THR  = 3'd5;

    // Register reset values
    localparam logic        RST_MODE       = 1'b0;
    localparam logic [4:0]  RST_TEMPLATE_W = 5'd8;
    localparam logic [4:0]  RST_TEMPLATE_H = 5'd8;
    localparam logic [10:0] RST_IMAGE_W    = 11'd1024;
    localparam logic [16:0] RST_MATCH_THR  = 17'd63570;
    localparam logic [32:0] RST_ANGLE_THR  = 33'd4294963001;

    // Input commands and matching modes
    localparam logic CMD_TEMPLATE = 1'b0;
    localparam logic CMD_IMAGE    = 1'b1;
    localparam logic MODE_MATCH   = 1'b0;
    localparam logic MODE_ANGLE   = 1'b1;

    // Digit-serial multiplier
    localparam int MUL_W     = 64;
    localparam int DIGIT_W   = 16;
    localparam int MUL_STEPS = MUL_W / DIGIT_W;
    localparam int MUL_CNT_W = 3;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] window_count;
    } out_item_t;

    typedef struct packed {
        logic        mode;
        logic [4:0]  template_width;
        logic [4:0]  template_height;
        logic [10:0] image_width;
        logic [16:0] match_threshold;
        logic [32:0] angle_threshold;
    } cfg_t;

    typedef struct packed {
        logic              check;
        logic              last;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic [DIM_W-1:0]  tw;
        logic [DIM_W-1:0]  th;
    } job_t;

    typedef struct packed {
        logic               t_en;
        logic [TADDR_W-1:0] t_addr;
        logic               l_en;
        logic [SLOT_W-1:0]  l_slot;
        logic [COL_W-1:0]   l_col;
        logic [PIX_W-1:0]   data;
    } mem_wr_t;

endpackage

FILE: hdl/tmc_fifo.sv
// Small synchronous FIFO used for the job queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps

module tmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Store data
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tmc_front.sv
// Front end: accepts pixels, tracks template index and image position,
// issues memory writes and window jobs. Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_front #(
    parameter int TMW = 16,
    parameter int TMH = 16,
    parameter int IMW = 1024,
    parameter int IMH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tmc_pkg::cfg_t    cfg,
    input  logic             accept,
    input  tmc_pkg::in_item_t item,
    input  logic             job_done,
    output logic             busy,
    output tmc_pkg::mem_wr_t wr,
    output logic             job_push,
    output tmc_pkg::job_t    job
);

    localparam int TDEPTH = TMW * TMH;
    localparam int TI_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TW_W   = $clog2(TMW + 1);
    localparam int TH_W   = $clog2(TMH + 1);
    localparam int IW_W   = $clog2(IMW + 1);
    localparam int CP_W   = $clog2(IMW + 1);
    localparam int ROW_W  = $clog2(IMH);
    localparam int SL_W   = (TMH > 1) ? $clog2(TMH) : 1;

    logic [TI_W-1:0]  tidx_reg, tidx_next;
    logic [CP_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SL_W-1:0]  slot_reg, slot_next;
    logic             busy_reg, busy_next;

    logic [TW_W-1:0]  tw;
    logic [TH_W-1:0]  th;
    logic [IW_W-1:0]  iw;
    logic [CP_W-1:0]  col_eff;
    logic [CP_W-1:0]  col_inc;
    logic             check;
    logic             is_image;

    // Clamp dimensions into their supported range
    always_comb
    begin
        if (cfg.template_width == '0)
            tw = TW_W'(1);
        else if (32'(cfg.template_width) > TMW)
            tw = TW_W'(TMW);
        else
            tw = TW_W'(cfg.template_width);

        if (cfg.template_height == '0)
            th = TH_W'(1);
        else if (32'(cfg.template_height) > TMH)
            th = TH_W'(TMH);
        else
            th = TH_W'(cfg.template_height);

        if (cfg.image_width == '0)
            iw = IW_W'(1);
        else if (32'(cfg.image_width) > IMW)
            iw = IW_W'(IMW);
        else
            iw = IW_W'(cfg.image_width);
    end

    // Classify the pixel
    assign is_image = (item.command == tmc_pkg::CMD_IMAGE);
    assign col_eff  = (32'(col_reg) >= 32'(iw)) ? '0 : col_reg;
    assign col_inc  = col_eff + 1'b1;
    assign check    = (32'(col_eff) >= 32'(tw) - 32'd1) && (32'(row_reg) >= 32'(th) - 32'd1);

    // Memory write requests
    always_comb
    begin
        wr.t_en   = accept && !is_image;
        wr.t_addr = tmc_pkg::TADDR_W'(tidx_reg);
        wr.l_en   = accept && is_image;
        wr.l_slot = tmc_pkg::SLOT_W'(slot_reg);
        wr.l_col  = tmc_pkg::COL_W'(col_eff);
        wr.data   = item.pixel;
    end

    // Window jobs
    assign job_push  = accept && is_image && (check || item.last);
    assign job.check = check;
    assign job.last  = item.last;
    assign job.col   = tmc_pkg::COL_W'(col_eff);
    assign job.slot  = tmc_pkg::SLOT_W'(slot_reg);
    assign job.tw    = tmc_pkg::DIM_W'(tw);
    assign job.th    = tmc_pkg::DIM_W'(th);
    assign busy      = busy_reg;

    // Advance template index and image position
    always_comb
    begin
        tidx_next = tidx_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        busy_next = busy_reg;
        if (job_done)
        begin
            busy_next = 1'b0;
        end
        if (job_push)
        begin
            busy_next = 1'b1;
        end
        if (accept && !is_image)
        begin
            if (item.last || tidx_reg == TI_W'(TDEPTH - 1))
                tidx_next = '0;
            else
                tidx_next = tidx_reg + 1'b1;
        end
        if (accept && is_image)
        begin
            if (item.last)
            begin
                col_next  = '0;
                row_next  = '0;
                slot_next = '0;
            end
            else if (32'(col_inc) >= 32'(iw))
            begin
                col_next = '0;
                if (row_reg < ROW_W'(IMH - 1))
                    row_next = row_reg + 1'b1;
                slot_next = (slot_reg == SL_W'(TMH - 1)) ? '0 : slot_reg + 1'b1;
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tidx_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            tidx_reg <= tidx_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: hdl/tmc_mul.sv
// Digit-serial 64x64 multiplier, one 16-bit digit of b per cycle.
// Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmc_pkg::MUL_W-1:0]  a,
    input  logic [tmc_pkg::MUL_W-1:0]  b,
    output logic                       done,
    output logic [2*tmc_pkg::MUL_W-1:0] p
);

    localparam int MW = tmc_pkg::MUL_W;
    localparam int DW = tmc_pkg::DIGIT_W;
    localparam int CW = tmc_pkg::MUL_CNT_W;

    logic [MW-1:0]   a_reg, b_reg;
    logic [2*MW-1:0] acc_reg;
    logic [CW-1:0]   cnt_reg;
    logic            run_reg, done_reg;
    logic [MW+DW-1:0] part;

    assign part = a_reg * b_reg[MW-1 -: DW];
    assign done = done_reg;
    assign p    = acc_reg;

    // Load operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= (acc_reg << DW) + (2*MW)'(part);
            b_reg   <= b_reg << DW;
        end
    end

    // Count digits, most significant first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(tmc_pkg::MUL_STEPS);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/tmc_back.sv
// Back end: holds template and line memories, walks each window one pixel
// per cycle, runs the threshold test and keeps the counts.
// Depends on tmc_pkg and tmc_mul.
`timescale 1ns / 1ps

module tmc_back #(
    parameter int TMW = 16,
    parameter int TMH = 16,
    parameter int IMW = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tmc_pkg::cfg_t     cfg,
    input  tmc_pkg::mem_wr_t  wr,
    input  logic              job_valid,
    input  tmc_pkg::job_t     job,
    output logic              job_pop,
    input  logic              out_full,
    output logic              out_push,
    output tmc_pkg::out_item_t out_item,
    output logic              job_done
);

    localparam int AREA   = TMW * TMH;
    localparam int TA_W   = (AREA > 1) ? $clog2(AREA) : 1;
    localparam int LDEPTH = TMH * IMW;
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int SL_W   = (TMH > 1) ? $clog2(TMH) : 1;
    localparam int CP_W   = $clog2(IMW);
    localparam int TC_W   = (TMW > 1) ? $clog2(TMW) : 1;
    localparam int RC_W   = (TMH > 1) ? $clog2(TMH) : 1;
    localparam int TW_W   = $clog2(TMW + 1);
    localparam int TH_W   = $clog2(TMH + 1);
    localparam int SUM_W  = $clog2(AREA * 255 + 1);
    localparam int SQ_W   = $clog2(AREA * 65025 + 1);
    localparam int MW     = tmc_pkg::MUL_W;
    localparam int CNT_W  = tmc_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_MSTART = 3'd2;
    localparam logic [2:0] ST_MWAIT  = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [7:0] tmem [AREA];
    logic [7:0] lmem [LDEPTH];

    logic [2:0]      state_reg, state_next;
    logic            last_reg;
    logic [TW_W-1:0] tw_reg;
    logic [TH_W-1:0] th_reg;
    logic [CP_W-1:0] col0_reg, col_cur_reg;
    logic [SL_W-1:0] slot_cur_reg;
    logic [TC_W-1:0] c_reg;
    logic [RC_W-1:0] r_reg;
    logic [TA_W-1:0] t_cnt_reg;
    logic            issue_v_reg, rd_v_reg, pr_v_reg;
    logic [7:0]      t_rd_reg, l_rd_reg, t_pipe_reg, l_pipe_reg;
    logic [15:0]     tp_reg, pp_reg, tt_reg;
    logic [SQ_W-1:0]  dot_reg, we_reg, te_reg;
    logic [SUM_W-1:0] ws_reg, ts_reg;
    logic [1:0]      step_reg;
    logic [MW-1:0]   p0_reg, p1_reg;
    logic [2*MW-1:0] p2_reg;
    logic            hit_reg;
    logic [CNT_W-1:0] hits_reg, wins_reg;
    logic            done_reg;

    logic [LA_W-1:0] l_rd_addr, l_wr_addr;
    logic [31:0]     slot_start;
    logic            drained, no_test, last_step, mul_hit;
    logic            mul_start, mul_done;
    logic [MW-1:0]   mul_a, mul_b;
    logic [2*MW-1:0] mul_p;

    // Memory addresses
    assign l_wr_addr  = LA_W'(32'(wr.l_slot) * IMW + 32'(wr.l_col));
    assign l_rd_addr  = LA_W'(32'(slot_cur_reg) * IMW + 32'(col_cur_reg));
    assign slot_start = 32'(job.slot) + TMH - 32'(job.th) + 32'd1;

    // Template memory
    always_ff @(posedge clk)
    begin
        if (wr.t_en)
        begin
            tmem[TA_W'(wr.t_addr)] <= wr.data;
        end
        t_rd_reg <= tmem[t_cnt_reg];
    end

    // Line memory
    always_ff @(posedge clk)
    begin
        if (wr.l_en)
        begin
            lmem[l_wr_addr] <= wr.data;
        end
        l_rd_reg <= lmem[l_rd_addr];
    end

    // Products and accumulation
    always_ff @(posedge clk)
    begin
        tp_reg     <= 16'(t_rd_reg) * 16'(l_rd_reg);
        pp_reg     <= 16'(l_rd_reg) * 16'(l_rd_reg);
        tt_reg     <= 16'(t_rd_reg) * 16'(t_rd_reg);
        t_pipe_reg <= t_rd_reg;
        l_pipe_reg <= l_rd_reg;
        if (state_reg == ST_IDLE)
        begin
            dot_reg <= '0;
            we_reg  <= '0;
            te_reg  <= '0;
            ws_reg  <= '0;
            ts_reg  <= '0;
        end
        else if (pr_v_reg)
        begin
            dot_reg <= dot_reg + SQ_W'(tp_reg);
            we_reg  <= we_reg + SQ_W'(pp_reg);
            te_reg  <= te_reg + SQ_W'(tt_reg);
            ws_reg  <= ws_reg + SUM_W'(l_pipe_reg);
            ts_reg  <= ts_reg + SUM_W'(t_pipe_reg);
        end
    end

    // Multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cfg.mode == tmc_pkg::MODE_MATCH)
        begin
            unique case (step_reg)
                2'd0:
                begin
                    mul_a = MW'(cfg.match_threshold);
                    mul_b = MW'(ts_reg);
                end
                default:
                begin
                    mul_a = p0_reg;
                    mul_b = MW'(ws_reg);
                end
            endcase
        end
        else
        begin
            unique case (step_reg)
                2'd0:
                begin
                    mul_a = MW'(cfg.angle_threshold);
                    mul_b = MW'(we_reg);
                end
                2'd1:
                begin
                    mul_a = MW'(cfg.angle_threshold);
                    mul_b = MW'(te_reg);
                end
                2'd2:
                begin
                    mul_a = p0_reg;
                    mul_b = p1_reg;
                end
                default:
                begin
                    mul_a = MW'(dot_reg);
                    mul_b = MW'(dot_reg);
                end
            endcase
        end
    end

    assign mul_start = (state_reg == ST_MSTART);

    tmc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Test decisions
    assign drained   = !issue_v_reg && !rd_v_reg && !pr_v_reg;
    assign no_test   = (cfg.mode == tmc_pkg::MODE_MATCH) ? (ws_reg == '0 || ts_reg == '0)
                                                         : (dot_reg == '0);
    assign last_step = (cfg.mode == tmc_pkg::MODE_MATCH) ? (step_reg == 2'd1)
                                                         : (step_reg == 2'd3);
    assign mul_hit   = (cfg.mode == tmc_pkg::MODE_MATCH)
                       ? ((((2*MW)'(dot_reg)) << 16) >= mul_p)
                       : (p2_reg < {mul_p[MW-1:0], {MW{1'b0}}});

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign out_push = (state_reg == ST_EMIT) && !out_full;
    assign out_item.hit_count    = hits_reg;
    assign out_item.window_count = wins_reg;
    assign job_done = done_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    state_next = job.check ? ST_RUN : ST_EMIT;
            end
            ST_RUN:
            begin
                if (drained)
                    state_next = no_test ? ST_UPD : ST_MSTART;
            end
            ST_MSTART:
                state_next = ST_MWAIT;
            ST_MWAIT:
            begin
                if (mul_done)
                    state_next = last_step ? ST_UPD : ST_MSTART;
            end
            ST_UPD:
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (!out_full)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Window walk and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issue_v_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            pr_v_reg    <= 1'b0;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            hits_reg    <= '0;
            wins_reg    <= '0;
            done_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == ST_RUN) && issue_v_reg;
            pr_v_reg  <= rd_v_reg;
            done_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        last_reg    <= job.last;
                        issue_v_reg <= job.check;
                        step_reg    <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issue_v_reg && 32'(c_reg) == 32'(tw_reg) - 32'd1
                        && 32'(r_reg) == 32'(th_reg) - 32'd1)
                    begin
                        issue_v_reg <= 1'b0;
                    end
                    if (drained && no_test)
                    begin
                        hit_reg <= 1'b0;
                    end
                end
                ST_MSTART:
                begin
                end
                ST_MWAIT:
                begin
                    if (mul_done)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (last_step)
                            hit_reg <= mul_hit;
                    end
                end
                ST_UPD:
                begin
                    if (wins_reg != tmc_pkg::COUNT_MAX)
                        wins_reg <= wins_reg + 1'b1;
                    if (hit_reg && hits_reg != tmc_pkg::COUNT_MAX)
                        hits_reg <= hits_reg + 1'b1;
                    if (!last_reg)
                        done_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (!out_full)
                    begin
                        hits_reg <= '0;
                        wins_reg <= '0;
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Window counters and intermediate products
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            tw_reg       <= TW_W'(job.tw);
            th_reg       <= TH_W'(job.th);
            col0_reg     <= CP_W'(32'(job.col) - 32'(job.tw) + 32'd1);
            col_cur_reg  <= CP_W'(32'(job.col) - 32'(job.tw) + 32'd1);
            slot_cur_reg <= (slot_start >= TMH) ? SL_W'(slot_start - TMH) : SL_W'(slot_start);
            c_reg        <= '0;
            r_reg        <= '0;
            t_cnt_reg    <= '0;
        end
        else if (state_reg == ST_RUN && issue_v_reg)
        begin
            t_cnt_reg <= t_cnt_reg + 1'b1;
            if (32'(c_reg) == 32'(tw_reg) - 32'd1)
            begin
                c_reg        <= '0;
                col_cur_reg  <= col0_reg;
                r_reg        <= r_reg + 1'b1;
                slot_cur_reg <= (slot_cur_reg == SL_W'(TMH - 1)) ? '0 : slot_cur_reg + 1'b1;
            end
            else
            begin
                c_reg       <= c_reg + 1'b1;
                col_cur_reg <= col_cur_reg + 1'b1;
            end
        end
        if (state_reg == ST_MWAIT && mul_done)
        begin
            unique case (step_reg)
                2'd0: p0_reg <= mul_p[MW-1:0];
                2'd1: p1_reg <= mul_p[MW-1:0];
                2'd2: p2_reg <= mul_p;
                default: p2_reg <= p2_reg;
            endcase
        end
    end

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= wins_reg)
        else $error("hit count exceeds window count");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MWAIT)
        else $error("multiplier finished outside its wait state");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |-> state_reg == ST_IDLE)
        else $error("job done signaled while back end busy");

endmodule

FILE: hdl/template_match_counter_top.sv
// Top level: configuration registers, front end, job queue, back end and
// result queue. Depends on tmc_pkg, tmc_fifo, tmc_front, tmc_back.
// Template pixels and image pixels that complete no window do not hold full.
// A pixel that completes a window holds full until the back end is done with it,
// in matching mode, in angle mode and when a zero sum or zero dot skips the test:
// the window is walked one pixel a cycle, then, unless the test is skipped, the 64x64 multiplies run one after another.
// The last image pixel holds full until its result is pushed (also with no
// window); a full result queue adds its stall.
// Reset clears control, position and counts; memories are not cleared.
`timescale 1ns / 1ps

module template_match_counter_top #(
    parameter int TEMPLATE_MAX_W = 16,
    parameter int TEMPLATE_MAX_H = 16,
    parameter int IMAGE_MAX_W    = 1024,
    parameter int IMAGE_MAX_H    = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tmc_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output tmc_pkg::out_item_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int JOB_W = $bits(tmc_pkg::job_t);
    localparam int OUT_W = $bits(tmc_pkg::out_item_t);

    logic        mode_reg;
    logic [4:0]  tw_reg, th_reg;
    logic [10:0] iw_reg;
    logic [16:0] mthr_reg;
    logic [32:0] athr_reg;

    tmc_pkg::cfg_t      cfg;
    tmc_pkg::mem_wr_t   wr;
    tmc_pkg::job_t      job_in, job_out;
    tmc_pkg::out_item_t out_item;
    logic [JOB_W-1:0]   job_rdata;
    logic [OUT_W-1:0]   out_rdata;
    logic               accept, busy, job_push, job_pop, job_empty, job_full, job_done;
    logic               out_push, out_full, cfg_wr;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tmc_pkg::RST_MODE;
            tw_reg   <= tmc_pkg::RST_TEMPLATE_W;
            th_reg   <= tmc_pkg::RST_TEMPLATE_H;
            iw_reg   <= tmc_pkg::RST_IMAGE_W;
            mthr_reg <= tmc_pkg::RST_MATCH_THR;
            athr_reg <= tmc_pkg::RST_ANGLE_THR;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                tmc_pkg::REG_MODE:       mode_reg <= pwdata[0];
                tmc_pkg::REG_TEMPLATE_W: tw_reg   <= pwdata[4:0];
                tmc_pkg::REG_TEMPLATE_H: th_reg   <= pwdata[4:0];
                tmc_pkg::REG_IMAGE_W:    iw_reg   <= pwdata[10:0];
                tmc_pkg::REG_MATCH_THR:  mthr_reg <= pwdata[16:0];
                tmc_pkg::REG_ANGLE_THR:  athr_reg <= pwdata[32:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            tmc_pkg::REG_MODE:       prdata = 64'(mode_reg);
            tmc_pkg::REG_TEMPLATE_W: prdata = 64'(tw_reg);
            tmc_pkg::REG_TEMPLATE_H: prdata = 64'(th_reg);
            tmc_pkg::REG_IMAGE_W:    prdata = 64'(iw_reg);
            tmc_pkg::REG_MATCH_THR:  prdata = 64'(mthr_reg);
            tmc_pkg::REG_ANGLE_THR:  prdata = 64'(athr_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.mode            = mode_reg;
    assign cfg.template_width  = tw_reg;
    assign cfg.template_height = th_reg;
    assign cfg.image_width     = iw_reg;
    assign cfg.match_threshold = mthr_reg;
    assign cfg.angle_threshold = athr_reg;

    // Input transfer
    assign full   = busy || job_full;
    assign accept = push && !full;

    tmc_front #(
        .TMW (TEMPLATE_MAX_W),
        .TMH (TEMPLATE_MAX_H),
        .IMW (IMAGE_MAX_W),
        .IMH (IMAGE_MAX_H)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .item     (item),
        .job_done (job_done),
        .busy     (busy),
        .wr       (wr),
        .job_push (job_push),
        .job      (job_in)
    );

    tmc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .pop   (job_pop),
        .rdata (job_rdata),
        .full  (job_full),
        .empty (job_empty)
    );

    assign job_out = tmc_pkg::job_t'(job_rdata);

    tmc_back #(
        .TMW (TEMPLATE_MAX_W),
        .TMH (TEMPLATE_MAX_H),
        .IMW (IMAGE_MAX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .wr        (wr),
        .job_valid (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item),
        .job_done  (job_done)
    );

    // Result queue
    tmc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty)
    );

    assign result = tmc_pkg::out_item_t'(out_rdata);

endmodule
